// ----- src/tcbm_pkg.sv -----
// ----------------------------------------------------------------------------
// tcbm_pkg
// Shared widths, command codes and types for the tensor contraction
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbm_pkg;

  // Field widths of the channels.
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 16;
  // Width of the clamped accumulator plus bias; holds +/-(2^40 + 2^31).
  localparam int SUM_W  = 42;

  // Number of weight entries the index field can reach.
  localparam int IDX_SPAN = 1 << IDX_W;

  // Command codes.
  localparam logic [0:0] CMD_LOAD = 1'b0;
  localparam logic [0:0] CMD_MAC  = 1'b1;

  // Saturation limits.
  localparam logic signed [ACC_W-1:0]  ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]  ACC_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0]  ACC_CLAMP = 64'sh0000_0100_0000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN  = 32'sh8000_0000;

  // One multiply-accumulate operation after the weight read was issued.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bias;
    logic                     last;
    logic                     in_range;
  } mac_op_t;

endpackage

`default_nettype wire

// ----- src/tcbm_in_if.sv -----
// ----------------------------------------------------------------------------
// tcbm_in_if
// Input channel: weight loads and tensor elements with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcbm_in_if;
  logic                             valid;
  logic                             ready;
  logic [0:0]                       command;
  logic [tcbm_pkg::IDX_W-1:0]       index;
  logic signed [tcbm_pkg::DATA_W-1:0] value;
  logic signed [tcbm_pkg::DATA_W-1:0] bias;
  logic                             last;

  modport source (output valid, command, index, value, bias, last, input ready);
  modport sink   (input valid, command, index, value, bias, last, output ready);
endinterface

`default_nettype wire

// ----- src/tcbm_out_if.sv -----
// ----------------------------------------------------------------------------
// tcbm_out_if
// Result channel: saturated sums with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcbm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tcbm_pkg::DATA_W-1:0] sum_out;
  logic                               saturated;

  modport source (output valid, sum_out, saturated, input ready);
  modport sink   (input valid, sum_out, saturated, output ready);
endinterface

`default_nettype wire

// ----- src/tcbm_weight_mem.sv -----
// ----------------------------------------------------------------------------
// tcbm_weight_mem
// Weight store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_weight_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [tcbm_pkg::DATA_W-1:0]   wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [tcbm_pkg::DATA_W-1:0]   rd_data
);

  logic [tcbm_pkg::DATA_W-1:0] mem [DEPTH];

  // A write lands at the edge it is issued, so any read issued after that
  // edge already sees the new word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/tcbm_mac.sv -----
// ----------------------------------------------------------------------------
// tcbm_mac
// Multiply, accumulate and finalize stages with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_mac (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        op_valid,
  input  wire tcbm_pkg::mac_op_t           op,
  input  wire logic [tcbm_pkg::DATA_W-1:0] weight,
  output logic                             op_take,
  tcbm_out_if.source                       out_ch
);

  // Product stage.
  logic                               p_v_r, p_v_nxt;
  logic signed [tcbm_pkg::ACC_W-1:0]  prod_r;
  logic signed [tcbm_pkg::DATA_W-1:0] p_bias_r;
  logic                               p_last_r;

  // Accumulator.
  logic signed [tcbm_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  // Finalize stage.
  logic                               f_v_r, f_v_nxt;
  logic signed [tcbm_pkg::ACC_W-1:0]  f_acc_r;
  logic signed [tcbm_pkg::DATA_W-1:0] f_bias_r;

  // Result register.
  logic                               o_v_r, o_v_nxt;
  logic signed [tcbm_pkg::DATA_W-1:0] o_sum_r;
  logic                               o_sat_r;

  logic                               o_free, s3_free, s3_go, s2_go;
  logic signed [tcbm_pkg::DATA_W-1:0] w_s;
  logic signed [tcbm_pkg::ACC_W-1:0]  prod_nxt, shifted, sum_raw, sum_sat;
  logic                               ovf;
  logic signed [tcbm_pkg::SUM_W-1:0]  a_cl, s_full;
  logic [tcbm_pkg::SUM_W-tcbm_pkg::DATA_W:0] s_hi;
  logic signed [tcbm_pkg::DATA_W-1:0] fin_sum;
  logic                               fin_sat;

  // Stage handshakes: each stage moves when the one after it has room.
  assign o_free  = !o_v_r || out_ch.ready;
  assign s3_go   = f_v_r && o_free;
  assign s3_free = !f_v_r || o_free;
  assign s2_go   = p_v_r && (!p_last_r || s3_free);
  assign op_take = !p_v_r || s2_go;

  // An index beyond the store multiplies by zero.
  assign w_s      = op.in_range ? $signed(weight) : '0;
  assign prod_nxt = w_s * op.value;

  // Floor shift back to Q48.16 and a saturating 64-bit add.
  always_comb begin
    shifted = prod_r >>> tcbm_pkg::FRAC_W;
    sum_raw = acc_r + shifted;
    ovf     = (acc_r[tcbm_pkg::ACC_W-1] == shifted[tcbm_pkg::ACC_W-1]) &&
              (sum_raw[tcbm_pkg::ACC_W-1] != acc_r[tcbm_pkg::ACC_W-1]);
    if (ovf) begin
      sum_sat = acc_r[tcbm_pkg::ACC_W-1] ? tcbm_pkg::ACC_MIN : tcbm_pkg::ACC_MAX;
    end else begin
      sum_sat = sum_raw;
    end
  end

  // The accumulator clears once the last element's sum moves on.
  always_comb begin
    acc_nxt = acc_r;
    if (s2_go) begin
      acc_nxt = p_last_r ? '0 : sum_sat;
    end
  end

  // Clamp, add the bias and saturate to 32 bits.
  always_comb begin
    if (f_acc_r > tcbm_pkg::ACC_CLAMP) begin
      a_cl = tcbm_pkg::ACC_CLAMP[tcbm_pkg::SUM_W-1:0];
    end else if (f_acc_r < -tcbm_pkg::ACC_CLAMP) begin
      a_cl = tcbm_pkg::SUM_W'(-tcbm_pkg::ACC_CLAMP);
    end else begin
      a_cl = f_acc_r[tcbm_pkg::SUM_W-1:0];
    end
    s_full = a_cl + tcbm_pkg::SUM_W'(f_bias_r);
    s_hi   = s_full[tcbm_pkg::SUM_W-1:tcbm_pkg::DATA_W-1];
    if ((&s_hi) || !(|s_hi)) begin
      fin_sum = s_full[tcbm_pkg::DATA_W-1:0];
      fin_sat = 1'b0;
    end else begin
      fin_sum = s_full[tcbm_pkg::SUM_W-1] ? tcbm_pkg::DATA_MIN : tcbm_pkg::DATA_MAX;
      fin_sat = 1'b1;
    end
  end

  // Next valid flags.
  always_comb begin
    p_v_nxt = p_v_r;
    if (op_valid && op_take) begin
      p_v_nxt = 1'b1;
    end else if (s2_go) begin
      p_v_nxt = 1'b0;
    end
    f_v_nxt = f_v_r;
    if (s2_go && p_last_r) begin
      f_v_nxt = 1'b1;
    end else if (s3_go) begin
      f_v_nxt = 1'b0;
    end
    o_v_nxt = o_v_r;
    if (s3_go) begin
      o_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_v_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      f_v_r <= 1'b0;
      o_v_r <= 1'b0;
      acc_r <= '0;
    end else begin
      p_v_r <= p_v_nxt;
      f_v_r <= f_v_nxt;
      o_v_r <= o_v_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op_valid && op_take) begin
      prod_r   <= prod_nxt;
      p_bias_r <= op.bias;
      p_last_r <= op.last;
    end
    if (s2_go && p_last_r) begin
      f_acc_r  <= sum_sat;
      f_bias_r <= p_bias_r;
    end
    if (s3_go) begin
      o_sum_r <= fin_sum;
      o_sat_r <= fin_sat;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.sum_out   = o_sum_r;
  assign out_ch.saturated = o_sat_r;

endmodule

`default_nettype wire

// ----- src/tensor_contract_bias_mac_unit.sv -----
// Path: a last element moves through the read, product and finalize stages into the result register.
// Throughput: one item per cycle while the result side does not stall; the single-port read
// of the weight store and the one-multiply-per-cycle product stage set that rate.
// Reset: synchronous, active low; clears all stage valid flags and the
// accumulator. The weight store is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
// tensor_contract_bias_mac_unit
// Loads weights into a store, then multiplies streamed tensor elements by
// their weights, accumulates, and emits bias plus sum on each last element.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_contract_bias_mac_unit #(
  parameter int WEIGHT_DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tcbm_in_if.sink   in_ch,
  tcbm_out_if.source out_ch
);

  // Only the entries the index field can reach are built.
  localparam int MEM_DEPTH = (WEIGHT_DEPTH < tcbm_pkg::IDX_SPAN) ?
                             WEIGHT_DEPTH : tcbm_pkg::IDX_SPAN;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic                        s1_v_r, s1_v_nxt;
  tcbm_pkg::mac_op_t           s1_r;
  logic                        s2_take, s1_free, fire, in_range, wr_en, rd_en;
  logic [AW-1:0]               addr;
  logic [tcbm_pkg::DATA_W-1:0] rd_data;

  // Input handshake and store access decode.
  assign s1_free  = !s1_v_r || s2_take;
  assign in_ch.ready = s1_free;
  assign fire     = in_ch.valid && s1_free;
  assign in_range = 32'(in_ch.index) < 32'(WEIGHT_DEPTH);
  assign addr     = in_ch.index[AW-1:0];
  assign wr_en    = fire && (in_ch.command == tcbm_pkg::CMD_LOAD) && in_range;
  assign rd_en    = fire && (in_ch.command == tcbm_pkg::CMD_MAC);

  tcbm_weight_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (in_ch.value),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Read stage: the element waits here while its weight comes out of the store.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (rd_en) begin
      s1_v_nxt = 1'b1;
    end else if (s2_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r.value    <= in_ch.value;
      s1_r.bias     <= in_ch.bias;
      s1_r.last     <= in_ch.last;
      s1_r.in_range <= in_range;
    end
  end

  tcbm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (s1_v_r),
    .op       (s1_r),
    .weight   (rd_data),
    .op_take  (s2_take),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- src/tcbm_checker.sv -----
// ----------------------------------------------------------------------------
// tcbm_checker
// Port-level checks on the result channel of the contraction unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [tcbm_pkg::DATA_W-1:0] sum_out,
  input wire logic                               saturated
);

  // A result held back by the sink stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sum_out) && $stable(saturated))
    else $error("result changed while stalled");

  // A clipped result sits exactly on one of the 32-bit limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      sum_out == tcbm_pkg::DATA_MAX || sum_out == tcbm_pkg::DATA_MIN)
    else $error("saturated result off the limits");

  // Reset leaves no result offered.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind tensor_contract_bias_mac_unit tcbm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sum_out   (out_ch.sum_out),
  .saturated (out_ch.saturated)
);

`default_nettype wire

// ----- dv/tensor_contract_bias_mac_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tensor_contract_bias_mac_unit_test
// Self-checking bench for the tensor contraction MAC unit. Weights are loaded
// into the store, then sums of tensor elements stream in with random gaps and
// result stalls. A bit-accurate Q16.16 predictor tracks the weight store and
// the 64-bit accumulator and checks every result in order.
// ----------------------------------------------------------------------------

module tensor_contract_bias_mac_unit_test;

  localparam int WEIGHT_SLOTS = 1024;
  localparam int STALL_LIMIT  = 400;
  localparam int TAIL_CYCLES  = 12;

  typedef struct packed {
    logic [0:0]                         command;
    logic [tcbm_pkg::IDX_W-1:0]         index;
    logic signed [tcbm_pkg::DATA_W-1:0] value;
    logic signed [tcbm_pkg::DATA_W-1:0] bias;
    logic                               last;
  } mac_item_t;

  typedef struct packed {
    logic signed [tcbm_pkg::DATA_W-1:0] sum_out;
    logic                               saturated;
  } sum_result_t;

  logic clk;
  logic rst_n;

  tcbm_in_if  in_if ();
  tcbm_out_if out_if ();

  tensor_contract_bias_mac_unit #(
    .WEIGHT_DEPTH (WEIGHT_SLOTS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Items waiting to be sent and sums waiting to come back.
  mac_item_t   item_backlog [$];
  sum_result_t sum_expected [$];

  // Mirror of the block's state.
  logic signed [tcbm_pkg::DATA_W-1:0] weight_mirror [WEIGHT_SLOTS];
  logic signed [tcbm_pkg::ACC_W-1:0]  running_sum;

  // Stimulus bookkeeping: which weight slots hold a value.
  bit weight_loaded [WEIGHT_SLOTS];
  int loaded_slots [$];

  int  queued_items;
  int  accepted_items;
  int  mismatches;
  int  stall_cycles;
  int  send_gap;
  int  take_gap;
  bit  send_calm;
  bit  take_calm;
  bit  quiet_tail;

  mac_item_t   driver_item;
  mac_item_t   seen_item;
  sum_result_t seen_sum;
  sum_result_t want_sum;

  // Clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // Applies one accepted item to the mirrored state and queues the sum it emits.
  task automatic predict_contraction(input mac_item_t it);
    logic signed [tcbm_pkg::ACC_W-1:0] weight;
    logic signed [tcbm_pkg::ACC_W-1:0] element;
    logic signed [tcbm_pkg::ACC_W-1:0] product;
    logic signed [tcbm_pkg::ACC_W-1:0] scaled;
    logic signed [tcbm_pkg::ACC_W:0]   wide;
    logic signed [tcbm_pkg::ACC_W-1:0] clamped;
    logic signed [tcbm_pkg::ACC_W-1:0] total;
    sum_result_t                       res;
    if (it.command == tcbm_pkg::CMD_LOAD) begin
      if (it.index < WEIGHT_SLOTS) weight_mirror[it.index] = it.value;
      return;
    end
    weight = '0;
    if (it.index < WEIGHT_SLOTS) weight = tcbm_pkg::ACC_W'(weight_mirror[it.index]);
    element = tcbm_pkg::ACC_W'(it.value);
    product = element * weight;
    // The Q32.32 product drops to Q48.16 with floor rounding.
    scaled = product >>> tcbm_pkg::FRAC_W;
    wide = $signed({running_sum[tcbm_pkg::ACC_W-1], running_sum}) +
           $signed({scaled[tcbm_pkg::ACC_W-1], scaled});
    if (wide[tcbm_pkg::ACC_W] != wide[tcbm_pkg::ACC_W-1]) begin
      running_sum = wide[tcbm_pkg::ACC_W] ? tcbm_pkg::ACC_MIN : tcbm_pkg::ACC_MAX;
    end else begin
      running_sum = wide[tcbm_pkg::ACC_W-1:0];
    end
    if (!it.last) return;
    // Clamp the accumulator, add the bias, then clip to 32 bits.
    clamped = running_sum;
    if (clamped > tcbm_pkg::ACC_CLAMP) clamped = tcbm_pkg::ACC_CLAMP;
    if (clamped < -tcbm_pkg::ACC_CLAMP) clamped = -tcbm_pkg::ACC_CLAMP;
    total = tcbm_pkg::ACC_W'(it.bias);
    total = total + clamped;
    res.saturated = 1'b1;
    if (total > tcbm_pkg::DATA_MAX) res.sum_out = tcbm_pkg::DATA_MAX;
    else if (total < tcbm_pkg::DATA_MIN) res.sum_out = tcbm_pkg::DATA_MIN;
    else begin
      res.sum_out = total[tcbm_pkg::DATA_W-1:0];
      res.saturated = 1'b0;
    end
    sum_expected.push_back(res);
    running_sum = '0;
  endtask

  task automatic queue_item(input logic [0:0] cmd, input int idx,
                            input logic [tcbm_pkg::DATA_W-1:0] val,
                            input logic [tcbm_pkg::DATA_W-1:0] bias, input bit last);
    mac_item_t it;
    it.command = cmd;
    it.index = idx[tcbm_pkg::IDX_W-1:0];
    it.value = val;
    it.bias = bias;
    it.last = last;
    item_backlog.push_back(it);
    queued_items++;
  endtask

  task automatic queue_load(input int idx, input logic [tcbm_pkg::DATA_W-1:0] val,
                            input logic [tcbm_pkg::DATA_W-1:0] bias, input bit last);
    if (!weight_loaded[idx]) begin
      weight_loaded[idx] = 1'b1;
      loaded_slots.push_back(idx);
    end
    queue_item(tcbm_pkg::CMD_LOAD, idx, val, bias, last);
  endtask

  task automatic queue_mac(input int idx, input logic [tcbm_pkg::DATA_W-1:0] val,
                           input logic [tcbm_pkg::DATA_W-1:0] bias, input bit last);
    queue_item(tcbm_pkg::CMD_MAC, idx, val, bias, last);
  endtask

  // Mostly small Q16.16 values; wide picks also reach the extremes and full range.
  function automatic logic signed [tcbm_pkg::DATA_W-1:0] pick_q16(input bit wide);
    int roll;
    roll = $urandom_range(0, 19);
    if (wide) begin
      if (roll == 0) return tcbm_pkg::DATA_MAX;
      if (roll == 1) return tcbm_pkg::DATA_MIN;
      if (roll < 8) return $urandom;
    end else if (roll == 0) begin
      return $urandom;
    end
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  // Only slots that were loaded are ever read.
  function automatic int pick_slot();
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  // One complete output sum, usually short, now and then long.
  task automatic queue_sum(input bit wide);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    for (int n = 0; n < len; n++) begin
      queue_mac(pick_slot(), pick_q16(wide), $urandom, n == len - 1);
    end
  endtask

  // Random traffic: mostly whole sums, with weight reloads and stray items mixed in.
  task automatic queue_traffic(input int goal);
    int roll;
    while (queued_items < goal) begin
      roll = $urandom_range(0, 19);
      if (roll < 3) begin
        repeat ($urandom_range(1, 6)) begin
          queue_load($urandom_range(0, WEIGHT_SLOTS - 1), pick_q16(roll == 0), $urandom,
                     1'($urandom_range(0, 1)));
        end
      end else if (roll < 5) begin
        // An element with no last flag folds into whichever sum comes next.
        queue_mac(pick_slot(), pick_q16(roll == 3), $urandom, 1'b0);
      end else begin
        queue_sum(roll < 9);
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_items != queued_items || sum_expected.size() != 0) @(posedge clk);
  endtask

  // Directed items: extremes, rounding, clipping and the ignored fields.
  task automatic queue_directed();
    queue_load(0, tcbm_pkg::DATA_MAX, 0, 1'b0);
    queue_load(1023, tcbm_pkg::DATA_MIN, 0, 1'b0);
    queue_load(512, 32'sh0001_0000, 0, 1'b0);
    queue_load(341, -32'sd1, 0, 1'b0);
    queue_load(682, 32'sh0000_8000, 0, 1'b0);
    queue_mac(512, 32'sh0003_0000, 32'sh0001_0000, 1'b1);
    // A tiny negative product rounds down to minus one LSB.
    queue_mac(341, 32'sd1, tcbm_pkg::DATA_MAX, 1'b0);
    queue_mac(512, 0, 0, 1'b1);
    // Last flag and bias on a weight load are ignored.
    queue_load(7, 32'sh0002_0000, tcbm_pkg::DATA_MIN, 1'b1);
    queue_mac(0, tcbm_pkg::DATA_MAX, tcbm_pkg::DATA_MAX, 1'b1);
    queue_mac(1023, tcbm_pkg::DATA_MAX, tcbm_pkg::DATA_MIN, 1'b1);
    queue_mac(1023, tcbm_pkg::DATA_MIN, tcbm_pkg::DATA_MIN, 1'b1);
    queue_mac(682, tcbm_pkg::DATA_MIN, tcbm_pkg::DATA_MAX, 1'b1);
    queue_mac(512, tcbm_pkg::DATA_MAX, 1, 1'b1);
    queue_mac(512, tcbm_pkg::DATA_MAX, 0, 1'b1);
    queue_mac(512, tcbm_pkg::DATA_MIN, 0, 1'b1);
    queue_mac(512, tcbm_pkg::DATA_MIN, -32'sd1, 1'b1);
    // Large terms that cancel inside the accumulator.
    queue_mac(0, tcbm_pkg::DATA_MAX, 0, 1'b0);
    queue_mac(1023, tcbm_pkg::DATA_MAX, 0, 1'b0);
    queue_mac(512, 0, 0, 1'b1);
    queue_load(512, 32'sh0002_0000, 0, 1'b0);
    queue_mac(512, 32'sh0001_0000, 0, 1'b1);
    queue_mac(7, 32'sh0000_4000, 32'sh0000_0001, 1'b1);
  endtask

  // Input driver: sends backlog items with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (item_backlog.size() != 0) begin
        driver_item = item_backlog.pop_front();
        in_if.command <= driver_item.command;
        in_if.index <= driver_item.index;
        in_if.value <= driver_item.value;
        in_if.bias <= driver_item.bias;
        in_if.last <= driver_item.last;
        in_if.valid <= 1'b1;
        if (!quiet_tail && !send_calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 14);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: ready with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_gap <= 0;
    end else if (take_gap != 0) begin
      out_if.ready <= 1'b0;
      take_gap <= take_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet_tail && !take_calm && $urandom_range(0, 9) == 0) begin
        take_gap <= $urandom_range(1, 14);
      end
    end
  end

  // Stretches without idling on either side come and go.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) send_calm <= ~send_calm;
    if ($urandom_range(0, 199) == 0) take_calm <= ~take_calm;
  end

  // Monitor: checks results against the predictor and feeds it accepted items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen_sum.sum_out = out_if.sum_out;
        seen_sum.saturated = out_if.saturated;
        if (sum_expected.size() == 0) begin
          report_mismatch("unexpected result sum_out", 0, seen_sum.sum_out);
        end else begin
          want_sum = sum_expected.pop_front();
          if (seen_sum.sum_out !== want_sum.sum_out) begin
            report_mismatch("sum_out", want_sum.sum_out, seen_sum.sum_out);
          end
          if (seen_sum.saturated !== want_sum.saturated) begin
            report_mismatch("saturated", want_sum.saturated, seen_sum.saturated);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen_item.command = in_if.command;
        seen_item.index = in_if.index;
        seen_item.value = in_if.value;
        seen_item.bias = in_if.bias;
        seen_item.last = in_if.last;
        predict_contraction(seen_item);
        accepted_items++;
      end
    end
  end

  // Watchdog: counts cycles without progress while work is outstanding.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (item_backlog.size() == 0 && !in_if.valid && sum_expected.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = tcbm_pkg::CMD_LOAD;
    in_if.index = '0;
    in_if.value = '0;
    in_if.bias = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    running_sum = '0;
    queued_items = 0;
    accepted_items = 0;
    mismatches = 0;
    stall_cycles = 0;
    send_gap = 0;
    take_gap = 0;
    send_calm = 1'b0;
    take_calm = 1'b0;
    quiet_tail = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_drained();

    // Main random phase with idling on both sides.
    queue_traffic(queued_items + 1100);
    wait_drained();

    // Final stretch at full rate.
    quiet_tail = 1'b1;
    queue_traffic(queued_items + 450);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && sum_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
